### rtl/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH       = 16;
   localparam int PRIO_BITS   = 8;
   localparam int PAY_BITS    = 32;
   localparam int COUNT_BITS  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef struct packed {
      logic                 insert;
      logic                 remove;
      logic [PRIO_BITS-1:0] prio;
      logic [PAY_BITS-1:0]  payload;
   } cmd_type;

endpackage

### rtl/stable_sorted_priority_queue_unit.sv
// Sorted priority queue of DEPTH entries held in a row of compare-and-shift
// cells, head in cell 0. An item is taken when start is high and busy is low;
// busy is high during reset and up to the first edge without reset, so one item can
// be taken every cycle. Each item gives exactly one result, shown with
// rsp_valid for one cycle, in the cycle after the item was taken; the receiver
// cannot stall it. Equal priorities leave in arrival order. An insert into a
// full queue is dropped with status full, a remove from an empty queue reports
// status empty, and the removed fields read zero whenever no entry is removed.
module stable_sorted_priority_queue_unit import spq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_mode,
   input  logic [PRIO_BITS-1:0]  req_in_priority,
   input  logic [PAY_BITS-1:0]   req_in_payload,
   output logic                  rsp_valid,
   output logic [PRIO_BITS-1:0]  rsp_out_priority,
   output logic [PAY_BITS-1:0]   rsp_out_payload,
   output logic [1:0]            rsp_status,
   output logic [COUNT_BITS-1:0] rsp_occupancy
);

   logic                  accept;
   logic                  full, empty;
   cmd_type               cmd;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  busy_ff;

   logic                  valid_ff, valid_in;
   logic [PRIO_BITS-1:0]  out_priority_ff, out_priority_in;
   logic [PAY_BITS-1:0]   out_payload_ff, out_payload_in;
   status_type            status_ff, status_in;

   logic [DEPTH-1:0]     occupied;
   logic [DEPTH-1:0]     lower;
   logic [PRIO_BITS-1:0] cell_priority [DEPTH];
   logic [PAY_BITS-1:0]  cell_payload  [DEPTH];

   assign accept = start && !busy_ff;
   assign full   = (count_ff == COUNT_BITS'(DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      cmd.insert  = accept && (req_mode == MODE_INSERT) && !full;
      cmd.remove  = accept && (req_mode == MODE_REMOVE) && !empty;
      cmd.prio    = req_in_priority;
      cmd.payload = req_in_payload;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 lower_prev;
      logic [PRIO_BITS-1:0] left_priority, right_priority;
      logic [PAY_BITS-1:0]  left_payload, right_payload;

      assign occupied[i] = count_ff > COUNT_BITS'(i);

      if (i == 0) begin : g_head
         assign lower_prev    = 1'b0;
         assign left_priority = req_in_priority;
         assign left_payload  = req_in_payload;
      end else begin : g_body
         assign lower_prev    = lower[i-1];
         assign left_priority = cell_priority[i-1];
         assign left_payload  = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_priority = '0;
         assign right_payload  = '0;
      end else begin : g_mid
         assign right_priority = cell_priority[i+1];
         assign right_payload  = cell_payload[i+1];
      end

      spq_cell u_cell (
         .clock          (clock),
         .cmd            (cmd),
         .occupied       (occupied[i]),
         .lower_prev     (lower_prev),
         .left_priority  (left_priority),
         .left_payload   (left_payload),
         .right_priority (right_priority),
         .right_payload  (right_payload),
         .lower          (lower[i]),
         .priority_out   (cell_priority[i]),
         .payload_out    (cell_payload[i])
      );
   end

   always_comb begin
      count_in        = count_ff;
      valid_in        = accept;
      out_priority_in = '0;
      out_payload_in  = '0;
      status_in       = ST_OK;
      if (accept) begin
         unique case (req_mode)
            MODE_INSERT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end
            MODE_REMOVE: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  out_priority_in = cell_priority[0];
                  out_payload_in  = cell_payload[0];
                  count_in        = count_ff - COUNT_BITS'(1);
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
         busy_ff  <= 1'b1;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
         busy_ff  <= 1'b0;
      end
      out_priority_ff <= out_priority_in;
      out_payload_ff  <= out_payload_in;
      status_ff       <= status_in;
   end

   assign busy             = busy_ff;
   assign rsp_valid        = valid_ff;
   assign rsp_out_priority = out_priority_ff;
   assign rsp_out_payload  = out_payload_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = count_ff;

endmodule

### rtl/spq_cell.sv
module spq_cell import spq_pkg::*; (
   input  logic                 clock,
   input  cmd_type              cmd,
   input  logic                 occupied,
   input  logic                 lower_prev,
   input  logic [PRIO_BITS-1:0] left_priority,
   input  logic [PAY_BITS-1:0]  left_payload,
   input  logic [PRIO_BITS-1:0] right_priority,
   input  logic [PAY_BITS-1:0]  right_payload,
   output logic                 lower,
   output logic [PRIO_BITS-1:0] priority_out,
   output logic [PAY_BITS-1:0]  payload_out
);

   logic [PRIO_BITS-1:0] priority_ff, priority_in;
   logic [PAY_BITS-1:0]  payload_ff, payload_in;

   // free slot or a stored entry that the new item goes ahead of
   assign lower = !occupied || (priority_ff < cmd.prio);

   always_comb begin
      priority_in = priority_ff;
      payload_in  = payload_ff;
      if (cmd.insert && lower) begin
         if (lower_prev) begin
            priority_in = left_priority;
            payload_in  = left_payload;
         end else begin
            priority_in = cmd.prio;
            payload_in  = cmd.payload;
         end
      end else if (cmd.remove) begin
         priority_in = right_priority;
         payload_in  = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      priority_ff <= priority_in;
      payload_ff  <= payload_in;
   end

   assign priority_out = priority_ff;
   assign payload_out  = payload_ff;

endmodule

### rtl/spq_checker.sv
module spq_checker import spq_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [PRIO_BITS-1:0]  rsp_out_priority,
   input logic [PAY_BITS-1:0]   rsp_out_payload,
   input logic [1:0]            rsp_status,
   input logic [COUNT_BITS-1:0] rsp_occupancy
);

   // one result per item, in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("item without result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without item");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_out_priority == '0 && rsp_out_payload == '0))
      else $error("flagged result carries an entry");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_occupancy == COUNT_BITS'(DEPTH)))
      else $error("full status with free slots");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with stored entries");

endmodule

bind stable_sorted_priority_queue_unit spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_out_priority (rsp_out_priority),
   .rsp_out_payload  (rsp_out_payload),
   .rsp_status       (rsp_status),
   .rsp_occupancy    (rsp_occupancy)
);

### tb/sv/tb_stable_sorted_priority_queue_unit.sv
`timescale 1ns / 100ps

typedef logic [spq_pkg::PRIO_BITS-1:0] prio_type;

typedef struct packed {
   logic [spq_pkg::PRIO_BITS-1:0]  prio;
   logic [spq_pkg::PAY_BITS-1:0]   payload;
   logic [1:0]                     status;
   logic [spq_pkg::COUNT_BITS-1:0] occupancy;
} queue_reply_type;

class sorted_queue_scoreboard;
   logic [spq_pkg::PRIO_BITS-1:0] held_prio [spq_pkg::DEPTH];
   logic [spq_pkg::PAY_BITS-1:0]  held_payload [spq_pkg::DEPTH];
   int                            held_count = 0;
   queue_reply_type               awaited[$];
   int                            errors = 0;

   // stable insert after every entry of equal or higher priority, remove from the head
   function void note_item(spq_pkg::mode_type mode, logic [spq_pkg::PRIO_BITS-1:0] prio,
                           logic [spq_pkg::PAY_BITS-1:0] payload);
      queue_reply_type reply;
      int              slot;
      reply = '0;
      reply.status = spq_pkg::ST_OK;
      if (mode == spq_pkg::MODE_INSERT) begin
         if (held_count >= spq_pkg::DEPTH) begin
            reply.status = spq_pkg::ST_FULL;
         end else begin
            slot = held_count;
            for (int i = 0; i < held_count; i++) begin
               if (held_prio[i] < prio) begin
                  slot = i;
                  break;
               end
            end
            for (int i = held_count; i > slot; i--) begin
               held_prio[i]    = held_prio[i-1];
               held_payload[i] = held_payload[i-1];
            end
            held_prio[slot]    = prio;
            held_payload[slot] = payload;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            reply.status = spq_pkg::ST_EMPTY;
         end else begin
            reply.prio    = held_prio[0];
            reply.payload = held_payload[0];
            for (int i = 1; i < held_count; i++) begin
               held_prio[i-1]    = held_prio[i];
               held_payload[i-1] = held_payload[i];
            end
            held_count--;
         end
      end
      reply.occupancy = held_count[spq_pkg::COUNT_BITS-1:0];
      awaited.push_back(reply);
   endfunction

   function void check_result(queue_reply_type got);
      queue_reply_type want;
      if (awaited.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected result: prio %0d payload %h status %0d occupancy %0d",
                     got.prio, got.payload, got.status, got.occupancy);
         return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display({"mismatch: exp prio %0d payload %h status %0d occupancy %0d,",
                      " got prio %0d payload %h status %0d occupancy %0d"},
                     want.prio, want.payload, want.status, want.occupancy,
                     got.prio, got.payload, got.status, got.occupancy);
      end
   endfunction
endclass

module tb_stable_sorted_priority_queue_unit;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PHASE = 567;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_mode = 1'b0;
   logic [spq_pkg::PRIO_BITS-1:0] req_in_priority = '0;
   logic [spq_pkg::PAY_BITS-1:0]  req_in_payload = '0;
   logic                          rsp_valid;
   logic [spq_pkg::PRIO_BITS-1:0] rsp_out_priority;
   logic [spq_pkg::PAY_BITS-1:0]  rsp_out_payload;
   logic [1:0]                    rsp_status;
   logic [spq_pkg::COUNT_BITS-1:0] rsp_occupancy;

   sorted_queue_scoreboard ledger = new();
   int                     idle_pct = 0;
   int unsigned            cycle_count = 0;

   stable_sorted_priority_queue_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_in_priority  (req_in_priority),
      .req_in_payload   (req_in_payload),
      .rsp_valid        (rsp_valid),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // results are checked before the item taken at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            ledger.check_result({rsp_out_priority, rsp_out_payload, rsp_status, rsp_occupancy});
         if (start === 1'b1 && busy === 1'b0)
            ledger.note_item(spq_pkg::mode_type'(req_mode), req_in_priority, req_in_payload);
      end
   end

   task automatic send_item(spq_pkg::mode_type mode, logic [spq_pkg::PRIO_BITS-1:0] prio,
                            logic [spq_pkg::PAY_BITS-1:0] payload);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_in_priority <= prio;
      req_in_payload  <= payload;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (ledger.awaited.size() != 0);
   endtask

   // full range, a narrow band for ties, or the extremes
   function automatic logic [spq_pkg::PRIO_BITS-1:0] pick_priority();
      case ($urandom_range(2))
         0: return prio_type'($urandom_range(255));
         1: return prio_type'($urandom_range(3));
         default: return $urandom_range(1) ? 8'hff : 8'h00;
      endcase
   endfunction

   initial begin
      int                phase_idle [3];
      int                sent;
      int                insert_pct;
      int                burst;
      spq_pkg::mode_type mode;
      phase_idle = '{24, 52, 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(spq_pkg::MODE_REMOVE, 8'h00, 32'h0);
      send_item(spq_pkg::MODE_INSERT, 8'h00, 32'h0000_0000);
      send_item(spq_pkg::MODE_INSERT, 8'hff, 32'hffff_ffff);
      send_item(spq_pkg::MODE_INSERT, 8'd128, 32'h1111_0001);
      send_item(spq_pkg::MODE_INSERT, 8'd128, 32'h1111_0002);
      send_item(spq_pkg::MODE_INSERT, 8'd128, 32'h1111_0003);
      send_item(spq_pkg::MODE_INSERT, 8'd1, 32'h5555_aaaa);
      send_item(spq_pkg::MODE_INSERT, 8'd254, 32'haaaa_5555);
      repeat (9) send_item(spq_pkg::MODE_INSERT, prio_type'($urandom_range(127, 129)), $urandom);
      send_item(spq_pkg::MODE_INSERT, 8'd200, 32'hdead_beef);
      repeat (4) send_item(spq_pkg::MODE_REMOVE, prio_type'($urandom), $urandom);
      wait_for_drain();

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = phase_idle[phase];
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
            burst = $urandom_range(8, 40);
            repeat (burst) begin
               mode = ($urandom_range(99) < insert_pct) ? spq_pkg::MODE_INSERT
                                                          : spq_pkg::MODE_REMOVE;
               send_item(mode, pick_priority(), $urandom);
            end
            sent += burst;
         end
         wait_for_drain();
      end

      repeat (4) @(posedge clock);
      if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
